@@ rtl/ert_pkg.sv @@
// Shared types and constants for the epoch reclamation tracker.
package ert_pkg;

  localparam int unsigned EPOCH_W = 64;
  localparam logic [EPOCH_W-1:0] IDLE_EPOCH  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(1);

  typedef enum logic [2:0] {
    OP_ENTER   = 3'd0,
    OP_EXIT    = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_QUERY   = 3'd3,
    OP_RELEASE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNMATCHED = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

@@ rtl/epoch_reclamation_tracker.sv @@
// Epoch tracker: global epoch register and a slot memory of published epochs and depths.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  command | operation, slot, retire_ep              | taken when start & !busy
//  result  | epoch, reclaim_ok, advanced, status     | one cycle, marked by done
//
//  Enter, exit and release read the slot entry, then modify and write it back.
//  Advance and reclaim query walk every slot entry through the single memory
//  read port. Enter, exit and release items out of slot range, and items with
//  unknown codes, finish without a memory access.
//  After reset a clearing pass writes every entry idle; busy stays high until it ends.
//  The receiver cannot stall; a result is shown once, in the cycle that done is high.
module epoch_reclamation_tracker #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned NEST_LIMIT = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    slot,
  input  logic [ert_pkg::EPOCH_W-1:0]   retire_ep,
  output logic                          done,
  output logic [ert_pkg::EPOCH_W-1:0]   epoch,
  output logic                          reclaim_ok,
  output logic                          advanced,
  output logic [1:0]                    status
);

  localparam int IW = $clog2(SLOTS);
  localparam int DW = $clog2(64'(NEST_LIMIT) + 64'd1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(NEST_LIMIT);

  typedef struct packed {
    logic [ert_pkg::EPOCH_W-1:0] ep;
    logic [DW-1:0]               depth;
  } entry_t;

  localparam entry_t IDLE_ENTRY = '{ep: ert_pkg::IDLE_EPOCH, depth: '0};

  // slot memory
  entry_t mem [SLOTS];
  entry_t rd_data;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [IW-1:0]   mem_raddr;
  entry_t          mem_wdata;

  // control and payload registers
  ert_pkg::state_t  state, state_next;
  logic [IW-1:0]    cnt, cnt_next;
  logic [ert_pkg::EPOCH_W-1:0] glob, glob_next;
  logic [ert_pkg::EPOCH_W-1:0] min_ep, min_ep_next;
  logic             any_act, any_act_next;
  logic             rvalid, rvalid_next;
  ert_pkg::op_t     op_q, op_next;
  logic [IW-1:0]    idx_q, idx_next;
  logic [ert_pkg::EPOCH_W-1:0] retire_q, retire_next;
  logic             done_q, done_next;
  logic [ert_pkg::EPOCH_W-1:0] epoch_q, epoch_next;
  logic             ok_q, ok_next;
  logic             adv_q, adv_next;
  ert_pkg::status_t status_q, status_next;

  logic in_range;
  logic adv_go;

  assign in_range = 32'(slot) < SLOTS;

  // write and read the slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ert_pkg::S_CLEAR;
      cnt     <= '0;
      glob    <= ert_pkg::EPOCH_RESET;
      rvalid  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      glob    <= glob_next;
      rvalid  <= rvalid_next;
      done_q  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    min_ep   <= min_ep_next;
    any_act  <= any_act_next;
    op_q     <= op_next;
    idx_q    <= idx_next;
    retire_q <= retire_next;
    epoch_q  <= epoch_next;
    ok_q     <= ok_next;
    adv_q    <= adv_next;
    status_q <= status_next;
  end

  // next state, memory access and results
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    glob_next    = glob;
    min_ep_next  = min_ep;
    any_act_next = any_act;
    rvalid_next  = 1'b0;
    op_next      = op_q;
    idx_next     = idx_q;
    retire_next  = retire_q;
    done_next    = 1'b0;
    epoch_next   = epoch_q;
    ok_next      = 1'b0;
    adv_next     = 1'b0;
    status_next  = ert_pkg::STAT_OK;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = IDLE_ENTRY;
    mem_raddr    = IW'(slot);
    adv_go       = 1'b0;

    // fold in one entry from the scan
    if (rvalid && (rd_data.depth != '0)) begin
      any_act_next = 1'b1;
      if (rd_data.ep < min_ep) begin
        min_ep_next = rd_data.ep;
      end
    end

    case (state)
      ert_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        cnt_next  = cnt + IW'(1);
        if (cnt == LAST_IDX) begin
          cnt_next   = '0;
          state_next = ert_pkg::S_IDLE;
        end
      end

      ert_pkg::S_IDLE: begin
        if (start) begin
          op_next     = ert_pkg::op_t'(operation);
          idx_next    = IW'(slot);
          retire_next = retire_ep;
          epoch_next  = glob;
          case (operation)
            ert_pkg::OP_ENTER, ert_pkg::OP_EXIT, ert_pkg::OP_RELEASE: begin
              if (in_range) begin
                state_next = ert_pkg::S_ACCESS;
              end else begin
                done_next = 1'b1;
                if (operation == ert_pkg::OP_EXIT) begin
                  status_next = ert_pkg::STAT_UNMATCHED;
                end
              end
            end
            ert_pkg::OP_ADVANCE, ert_pkg::OP_QUERY: begin
              cnt_next     = '0;
              min_ep_next  = ert_pkg::IDLE_EPOCH;
              any_act_next = 1'b0;
              state_next   = ert_pkg::S_SCAN;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // modify the entry read in the previous cycle and write it back
      ert_pkg::S_ACCESS: begin
        done_next  = 1'b1;
        epoch_next = glob;
        state_next = ert_pkg::S_IDLE;
        case (op_q)
          ert_pkg::OP_ENTER: begin
            if (rd_data.depth == '0) begin
              mem_we    = 1'b1;
              mem_wdata = '{ep: glob, depth: DW'(1)};
            end else if (rd_data.depth == DEPTH_MAX) begin
              status_next = ert_pkg::STAT_OVERFLOW;
            end else begin
              mem_we     = 1'b1;
              mem_wdata  = '{ep: rd_data.ep, depth: rd_data.depth + DW'(1)};
              epoch_next = rd_data.ep;
            end
          end
          ert_pkg::OP_EXIT: begin
            if (rd_data.depth == '0) begin
              status_next = ert_pkg::STAT_UNMATCHED;
            end else begin
              mem_we = 1'b1;
              if (rd_data.depth == DW'(1)) begin
                mem_wdata = IDLE_ENTRY;
              end else begin
                mem_wdata = '{ep: rd_data.ep, depth: rd_data.depth - DW'(1)};
              end
            end
          end
          ert_pkg::OP_RELEASE: begin
            mem_we    = 1'b1;
            mem_wdata = IDLE_ENTRY;
          end
          default: begin
          end
        endcase
      end

      // walk every slot entry through the read port
      ert_pkg::S_SCAN: begin
        mem_raddr   = cnt;
        rvalid_next = 1'b1;
        cnt_next    = cnt + IW'(1);
        if (cnt == LAST_IDX) begin
          cnt_next   = '0;
          state_next = ert_pkg::S_DRAIN;
        end
      end

      ert_pkg::S_DRAIN: begin
        state_next = ert_pkg::S_FINISH;
      end

      // decide advance or reclaim from the least active epoch
      ert_pkg::S_FINISH: begin
        done_next  = 1'b1;
        epoch_next = glob;
        state_next = ert_pkg::S_IDLE;
        if (op_q == ert_pkg::OP_ADVANCE) begin
          adv_go = (!any_act || (min_ep >= glob)) && (glob != ert_pkg::IDLE_EPOCH);
          if (adv_go) begin
            glob_next  = glob + ert_pkg::EPOCH_W'(1);
            epoch_next = glob + ert_pkg::EPOCH_W'(1);
            adv_next   = 1'b1;
          end
        end else begin
          ok_next = !any_act || (retire_q < min_ep);
        end
      end

      default: begin
        state_next = ert_pkg::S_IDLE;
      end
    endcase
  end

  assign busy       = (state != ert_pkg::S_IDLE);
  assign done       = done_q;
  assign epoch      = epoch_q;
  assign reclaim_ok = ok_q;
  assign advanced   = adv_q;
  assign status     = status_q;

endmodule
